### hw/rtl/neighbor_word_generator_defines.svh
// Assertion macros used by the checker file of the neighbor word generator.
`ifndef NEIGHBOR_WORD_GENERATOR_DEFINES_SVH
`define NEIGHBOR_WORD_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NWG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("neighbor word generator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NWG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("neighbor word generator assertion failed");

`endif

### hw/rtl/nwg_pkg.sv
package nwg_pkg;

  localparam int MaxSeedLen   = 5;
  localparam int AlphabetSize = 20;
  localparam int ScoreWidth   = 8;
  localparam int LetterW      = 5;
  localparam int CodeW        = LetterW * MaxSeedLen;
  localparam int MatDepth     = AlphabetSize * AlphabetSize;
  localparam int MatAddrW     = $clog2(MatDepth);
  localparam int ThrWidth     = 11;
  localparam int SumW         = 12;
  localparam int LenW         = 3;
  localparam int CntW         = 5;
  localparam int ShiftW       = 5;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = ThrWidth;

  // Register indexes of the configuration channel.
  localparam logic [CfgIdxW-1:0] CFG_SEED_LEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEIGHBORS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd2;

  // Item kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic [LetterW-1:0]           letter_0;
    logic [LetterW-1:0]           letter_1;
    logic [LetterW-1:0]           letter_2;
    logic [LetterW-1:0]           letter_3;
    logic [LetterW-1:0]           letter_4;
    logic [2:0]                   mutate_position;
    logic [LetterW-1:0]           matrix_row;
    logic [LetterW-1:0]           matrix_col;
    logic signed [ScoreWidth-1:0] entry_score;
  } nwg_req_t;

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic [CodeW-1:0] word_code;
    logic             found;
    logic             last;
  } nwg_res_t;

  // Letter minus 'A' for each amino index in A R N D C Q E G H I L K M F P S T W Y V order.
  function automatic logic [LetterW-1:0] letter_offset(input logic [LetterW-1:0] idx);
    logic [LetterW-1:0] off;
    case (idx)
      5'd0:    off = 5'd0;
      5'd1:    off = 5'd17;
      5'd2:    off = 5'd13;
      5'd3:    off = 5'd3;
      5'd4:    off = 5'd2;
      5'd5:    off = 5'd16;
      5'd6:    off = 5'd4;
      5'd7:    off = 5'd6;
      5'd8:    off = 5'd7;
      5'd9:    off = 5'd8;
      5'd10:   off = 5'd11;
      5'd11:   off = 5'd10;
      5'd12:   off = 5'd12;
      5'd13:   off = 5'd5;
      5'd14:   off = 5'd15;
      5'd15:   off = 5'd18;
      5'd16:   off = 5'd19;
      5'd17:   off = 5'd22;
      5'd18:   off = 5'd24;
      5'd19:   off = 5'd21;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // Row-major matrix address: row * 20 + col, with row * 20 as (row << 4) + (row << 2).
  function automatic logic [MatAddrW-1:0] mat_addr(input logic [LetterW-1:0] row,
                                                   input logic [LetterW-1:0] col);
    return (MatAddrW'(row) << 4) + (MatAddrW'(row) << 2) + MatAddrW'(col);
  endfunction

  function automatic logic signed [SumW-1:0] score_ext(input logic [ScoreWidth-1:0] s);
    return SumW'(signed'(s));
  endfunction

endpackage

### hw/rtl/nwg_ram.sv
module nwg_ram #(
  parameter int Width = 8,
  parameter int Depth = 400
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/neighbor_word_generator.sv
// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           req_i (nwg_req_t)
// result    out        res_valid_o (strobe)      res_o (nwg_res_t)
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// A matrix write leaves the block idle and gives no result. A query with the neighbor
// search on passes the base, substitution, drain and finish states; the single read
// port of the score matrix fetches one entry a cycle: the diagonal scores, then all 20
// substitutions. Other queries go to the finish state; no command is taken while busy.
// Results come one per cycle at most and cannot be stalled. Reset is asynchronous and
// active low; the score matrix is not cleared and must be written before queries use it.
module neighbor_word_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  nwg_pkg::nwg_req_t                  req_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output nwg_pkg::nwg_res_t                  res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nwg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [nwg_pkg::CfgDataW-1:0]       cfg_data_i
);
  import nwg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SUBST,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                     state_q, state_d;
  logic [LenW-1:0]            seed_len_q, seed_len_d;
  logic                       nbr_en_q, nbr_en_d;
  logic signed [ThrWidth-1:0] thr_q, thr_d;
  logic [LetterW-1:0]         word_q [MaxSeedLen];
  logic [LetterW-1:0]         word_d [MaxSeedLen];
  logic [LenW-1:0]            len_q, len_d;
  logic [2:0]                 pos_q, pos_d;
  logic [LetterW-1:0]         orig_q, orig_d;
  logic [CodeW-1:0]           key_q, key_d;
  logic [CodeW-1:0]           mask_key_q, mask_key_d;
  logic [ShiftW-1:0]          shift_q, shift_d;
  logic                       bad_q, bad_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       rd_valid_q, rd_valid_d;
  logic                       rd_subst_q, rd_subst_d;
  logic [CntW-1:0]            rd_idx_q, rd_idx_d;
  logic signed [SumW-1:0]     base_q, base_d;
  logic                       pend_valid_q, pend_valid_d;
  logic [CodeW-1:0]           pend_word_q, pend_word_d;
  logic                       res_valid_q, res_valid_d;
  nwg_res_t                   res_q, res_d;

  logic                       ram_we;
  logic [MatAddrW-1:0]        ram_waddr;
  logic [MatAddrW-1:0]        ram_raddr;
  logic [ScoreWidth-1:0]      ram_rdata;

  // Decode of the incoming command beat.
  logic [LetterW-1:0]         letters_in [MaxSeedLen];
  logic [LetterW-1:0]         offs_in [MaxSeedLen];
  logic [LenW-1:0]            len_in;
  logic                       bad_in;
  logic [CodeW-1:0]           key_in;
  logic [LenW-1:0]            tail_in;
  logic [ShiftW-1:0]          shift_in;
  logic [LetterW-1:0]         orig_in;

  logic signed [SumW-1:0]     cand_sum;
  logic                       hit;
  logic [CodeW-1:0]           variant;

  assign letters_in[0] = req_i.letter_0;
  assign letters_in[1] = req_i.letter_1;
  assign letters_in[2] = req_i.letter_2;
  assign letters_in[3] = req_i.letter_3;
  assign letters_in[4] = req_i.letter_4;

  always_comb begin
    if (seed_len_q < 3'd3) begin
      len_in = 3'd3;
    end else if (seed_len_q > LenW'(MaxSeedLen)) begin
      len_in = LenW'(MaxSeedLen);
    end else begin
      len_in = seed_len_q;
    end
  end

  always_comb begin
    bad_in = (req_i.mutate_position >= len_in);
    for (int i = 0; i < MaxSeedLen; i++) begin
      offs_in[i] = letter_offset(letters_in[i]);
      if ((LenW'(i) < len_in) && (letters_in[i] >= LetterW'(AlphabetSize))) begin
        bad_in = 1'b1;
      end
    end
  end

  // First letter lands in the highest used field.
  always_comb begin
    case (len_in)
      3'd3:    key_in = {10'd0, offs_in[0], offs_in[1], offs_in[2]};
      3'd4:    key_in = {5'd0, offs_in[0], offs_in[1], offs_in[2], offs_in[3]};
      default: key_in = {offs_in[0], offs_in[1], offs_in[2], offs_in[3], offs_in[4]};
    endcase
  end

  assign tail_in  = len_in - 3'd1 - req_i.mutate_position;
  assign shift_in = ShiftW'({tail_in, 2'b00}) + ShiftW'(tail_in);
  assign orig_in  = (req_i.mutate_position < 3'(MaxSeedLen)) ?
                    letters_in[req_i.mutate_position] : '0;

  assign cand_sum = base_q + score_ext(ram_rdata);
  assign hit      = rd_valid_q && rd_subst_q && (rd_idx_q != orig_q) &&
                    (cand_sum >= SumW'(thr_q));
  assign variant  = mask_key_q | (CodeW'(letter_offset(rd_idx_q)) << shift_q);

  always_comb begin
    state_d      = state_q;
    seed_len_d   = seed_len_q;
    nbr_en_d     = nbr_en_q;
    thr_d        = thr_q;
    word_d       = word_q;
    len_d        = len_q;
    pos_d        = pos_q;
    orig_d       = orig_q;
    key_d        = key_q;
    mask_key_d   = mask_key_q;
    shift_d      = shift_q;
    bad_d        = bad_q;
    cnt_d        = cnt_q;
    rd_valid_d   = 1'b0;
    rd_subst_d   = rd_subst_q;
    rd_idx_d     = rd_idx_q;
    base_d       = base_q;
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = mat_addr(req_i.matrix_row, req_i.matrix_col);
    ram_raddr    = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEED_LEN:  seed_len_d = cfg_data_i[LenW-1:0];
        CFG_NEIGHBORS: nbr_en_d   = cfg_data_i[0];
        CFG_THRESHOLD: thr_d      = signed'(cfg_data_i);
        default: ;
      endcase
    end

    // Matrix data returned by the read issued in the previous cycle.
    if (rd_valid_q && !rd_subst_q && (rd_idx_q[2:0] != pos_q)) begin
      base_d = cand_sum;
    end
    if (hit) begin
      // A held hit goes out only once another one follows, so the final beat
      // can carry last.
      if (pend_valid_q) begin
        res_valid_d = 1'b1;
        res_d       = '{key_code: key_q, word_code: pend_word_q, found: 1'b1, last: 1'b0};
      end
      pend_valid_d = 1'b1;
      pend_word_d  = variant;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.req_type == REQ_WRITE) begin
            ram_we = (req_i.matrix_row < LetterW'(AlphabetSize)) &&
                     (req_i.matrix_col < LetterW'(AlphabetSize));
          end else begin
            word_d       = letters_in;
            len_d        = len_in;
            pos_d        = req_i.mutate_position;
            orig_d       = orig_in;
            key_d        = key_in;
            mask_key_d   = key_in & ~(CodeW'(5'h1F) << shift_in);
            shift_d      = shift_in;
            bad_d        = bad_in;
            cnt_d        = '0;
            base_d       = '0;
            pend_valid_d = !bad_in && (req_i.mutate_position == 3'd0);
            pend_word_d  = key_in;
            if (!bad_in && nbr_en_q) begin
              state_d = ST_BASE;
            end else begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_BASE: begin
        ram_raddr  = mat_addr(word_q[cnt_q[2:0]], word_q[cnt_q[2:0]]);
        rd_valid_d = 1'b1;
        rd_subst_d = 1'b0;
        rd_idx_d   = cnt_q;
        if (cnt_q == CntW'(len_q - 3'd1)) begin
          cnt_d   = '0;
          state_d = ST_SUBST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SUBST: begin
        ram_raddr  = mat_addr(orig_q, cnt_q);
        rd_valid_d = 1'b1;
        rd_subst_d = 1'b1;
        rd_idx_d   = cnt_q;
        if (cnt_q == CntW'(AlphabetSize - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        res_valid_d = 1'b1;
        if (bad_q) begin
          res_d = '{key_code: '0, word_code: '0, found: 1'b0, last: 1'b1};
        end else if (pend_valid_q) begin
          res_d = '{key_code: key_q, word_code: pend_word_q, found: 1'b1, last: 1'b1};
        end else begin
          res_d = '{key_code: key_q, word_code: '0, found: 1'b0, last: 1'b1};
        end
        pend_valid_d = 1'b0;
        bad_d        = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_len_q   <= 3'd3;
      nbr_en_q     <= 1'b1;
      thr_q        <= 11'sd11;
      word_q       <= '{default: '0};
      len_q        <= 3'd3;
      pos_q        <= '0;
      orig_q       <= '0;
      key_q        <= '0;
      mask_key_q   <= '0;
      shift_q      <= '0;
      bad_q        <= 1'b0;
      cnt_q        <= '0;
      rd_valid_q   <= 1'b0;
      rd_subst_q   <= 1'b0;
      rd_idx_q     <= '0;
      base_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_word_q  <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      seed_len_q   <= seed_len_d;
      nbr_en_q     <= nbr_en_d;
      thr_q        <= thr_d;
      word_q       <= word_d;
      len_q        <= len_d;
      pos_q        <= pos_d;
      orig_q       <= orig_d;
      key_q        <= key_d;
      mask_key_q   <= mask_key_d;
      shift_q      <= shift_d;
      bad_q        <= bad_d;
      cnt_q        <= cnt_d;
      rd_valid_q   <= rd_valid_d;
      rd_subst_q   <= rd_subst_d;
      rd_idx_q     <= rd_idx_d;
      base_q       <= base_d;
      pend_valid_q <= pend_valid_d;
      pend_word_q  <= pend_word_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  nwg_ram #(
    .Width (ScoreWidth),
    .Depth (MatDepth)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.entry_score),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

### hw/rtl/nwg_checker.sv
`include "neighbor_word_generator_defines.svh"

module nwg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input nwg_pkg::nwg_req_t req_i,
  input logic              busy_o,
  input logic              res_valid_o,
  input nwg_pkg::nwg_res_t res_o
);
  import nwg_pkg::*;

  // An empty result never carries a word.
  `NWG_ASSERT_IMP(a_empty_no_word, clk_i, rst_ni, res_valid_o && !res_o.found, res_o.word_code == '0)

  // A result shown while the block is idle closes its query.
  `NWG_ASSERT_IMP(a_idle_result_last, clk_i, rst_ni, res_valid_o && !busy_o, res_o.last)

  // An accepted query keeps the block busy in the following cycle.
  `NWG_ASSERT_NXT(a_query_busy, clk_i, rst_ni, start_i && !busy_o && (req_i.req_type == REQ_QUERY), busy_o)

  // A matrix write finishes at once and gives no result.
  `NWG_ASSERT_NXT(a_write_quiet, clk_i, rst_ni, start_i && !busy_o && (req_i.req_type == REQ_WRITE), !busy_o && !res_valid_o)

endmodule

bind neighbor_word_generator nwg_checker u_nwg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nwg_pkg::*;

  localparam int DrainCycles   = 40;
  localparam int WatchdogLimit = 3000;
  localparam int MinSeedLen    = 3;
  localparam int MinThreshold  = -640;
  localparam int MaxThreshold  = 635;
  localparam int ReqW          = $bits(nwg_req_t);
  localparam int PhaseItems    = 23;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam logic [LetterW-1:0] AMINO_C = 5'd4;
  localparam logic [LetterW-1:0] AMINO_W = 5'd17;

  localparam logic signed [ScoreWidth-1:0] ScoreMax = 8'sd127;
  localparam logic signed [ScoreWidth-1:0] ScoreMin = -8'sd128;

  // Letter minus 'A' for each amino index, index 0 in the lowest five bits.
  localparam logic [AlphabetSize*LetterW-1:0] AMINO_CODES = {
    5'd21, 5'd24, 5'd22, 5'd19, 5'd18, 5'd15, 5'd5, 5'd12, 5'd10, 5'd11,
    5'd8,  5'd7,  5'd6,  5'd4,  5'd16, 5'd2,  5'd3, 5'd13, 5'd17, 5'd0
  };

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                start_i;
  nwg_req_t            req_i;
  logic                busy_o;
  logic                res_valid_o;
  nwg_res_t            res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state: its own copy of the registers and the score matrix.
  logic [LenW-1:0]               reg_seed_len = 3'd3;
  logic                          reg_neighbors = 1'b1;
  int                            reg_threshold = 11;
  logic signed [ScoreWidth-1:0]  score_tbl [AlphabetSize][AlphabetSize];

  nwg_res_t expected_words [$];

  int  mismatch_count;
  int  writes_sent;
  int  queries_sent;
  int  cfg_writes;
  int  results_checked;
  int  words_found;
  int  quiet_cycles;
  bit  no_gaps;

  neighbor_word_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic queue_expected(input nwg_res_t r);
    expected_words.insert(expected_words.size(), r);
  endtask

  function automatic int active_len();
    if (reg_seed_len < MinSeedLen) return MinSeedLen;
    if (reg_seed_len > MaxSeedLen) return MaxSeedLen;
    return int'(reg_seed_len);
  endfunction

  function automatic logic [CodeW-1:0] pack_code(input logic [MaxSeedLen-1:0][LetterW-1:0] w,
                                                 input int len);
    logic [CodeW-1:0] code;
    int i;
    code = '0;
    for (i = 0; i < len; i++) begin
      code = (code << LetterW) | CodeW'(AMINO_CODES[w[i]*LetterW +: LetterW]);
    end
    return code;
  endfunction

  task automatic store_entry(input nwg_req_t r);
    if (r.matrix_row < AlphabetSize && r.matrix_col < AlphabetSize) begin
      score_tbl[r.matrix_row][r.matrix_col] = r.entry_score;
    end
  endtask

  // Works out every word a query emits. The newest word is held back so that the
  // final one can carry the last flag.
  task automatic predict_neighbors(input nwg_req_t r);
    logic [MaxSeedLen-1:0][LetterW-1:0] word;
    logic [MaxSeedLen-1:0][LetterW-1:0] variant;
    logic [CodeW-1:0] key;
    nwg_res_t held;
    bit have_held;
    bit bad;
    int len;
    int pos;
    int i;
    int k;
    int base;
    word = {r.letter_4, r.letter_3, r.letter_2, r.letter_1, r.letter_0};
    len  = active_len();
    pos  = int'(r.mutate_position);
    bad  = (pos >= len);
    for (i = 0; i < len; i++) begin
      if (word[i] >= AlphabetSize) bad = 1'b1;
    end
    if (bad) begin
      queue_expected('{key_code: '0, word_code: '0, found: 1'b0, last: 1'b1});
      return;
    end
    key       = pack_code(word, len);
    have_held = 1'b0;
    if (pos == 0) begin
      held      = '{key, key, 1'b1, 1'b0};
      have_held = 1'b1;
    end
    if (reg_neighbors) begin
      base = 0;
      for (i = 0; i < len; i++) begin
        if (i != pos) base += score_tbl[word[i]][word[i]];
      end
      for (k = 0; k < AlphabetSize; k++) begin
        if (k != word[pos] && base + score_tbl[word[pos]][k] >= reg_threshold) begin
          if (have_held) queue_expected(held);
          variant      = word;
          variant[pos] = LetterW'(k);
          held         = '{key, pack_code(variant, len), 1'b1, 1'b0};
          have_held    = 1'b1;
        end
      end
    end
    if (!have_held) held = '{key, '0, 1'b0, 1'b0};
    held.last = 1'b1;
    queue_expected(held);
  endtask

  function automatic nwg_req_t random_fill();
    return ReqW'({$urandom, $urandom});
  endfunction

  function automatic logic [LetterW-1:0] pick_amino();
    return LetterW'($urandom_range(0, AlphabetSize - 1));
  endfunction

  function automatic nwg_req_t make_query(input logic [LetterW-1:0] l0, l1, l2, l3, l4,
                                          input int pos);
    nwg_req_t r;
    r = random_fill();
    r.req_type        = REQ_QUERY;
    r.letter_0        = l0;
    r.letter_1        = l1;
    r.letter_2        = l2;
    r.letter_3        = l3;
    r.letter_4        = l4;
    r.mutate_position = 3'(pos);
    return r;
  endfunction

  // Sends one beat on the command channel; returns at the edge that accepts it.
  task automatic send_item(input nwg_req_t item);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      @(negedge clk);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start_i <= 1'b1;
    req_i   <= item;
    @(posedge clk);
    while (busy_o) @(posedge clk);
    if (item.req_type == REQ_QUERY) begin
      queries_sent++;
      predict_neighbors(item);
    end else begin
      writes_sent++;
      store_entry(item);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_SEED_LEN:  reg_seed_len  = data[LenW-1:0];
      CFG_NEIGHBORS: reg_neighbors = data[0];
      CFG_THRESHOLD: reg_threshold = $signed(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Unused upper data bits are filled with noise; the block must mask them.
  task automatic set_config(input int len, input bit en, input int thr);
    logic [CfgDataW-1:0] d;
    wait_drain();
    d = CfgDataW'($urandom);
    d[LenW-1:0] = len[LenW-1:0];
    cfg_write(CFG_SEED_LEN, d);
    d = CfgDataW'($urandom);
    d[0] = en;
    cfg_write(CFG_NEIGHBORS, d);
    cfg_write(CFG_THRESHOLD, CfgDataW'(thr));
  endtask

  function automatic nwg_req_t stray_write();
    nwg_req_t r;
    r = random_fill();
    r.req_type = REQ_WRITE;
    if ($urandom_range(0, 1)) r.matrix_row = LetterW'($urandom_range(AlphabetSize, 31));
    else                      r.matrix_col = LetterW'($urandom_range(AlphabetSize, 31));
    return r;
  endfunction

  function automatic nwg_req_t entry_write();
    nwg_req_t r;
    r = random_fill();
    r.req_type   = REQ_WRITE;
    r.matrix_row = pick_amino();
    r.matrix_col = pick_amino();
    return r;
  endfunction

  function automatic nwg_req_t good_query();
    nwg_req_t r;
    int len;
    len = active_len();
    r = random_fill();
    r.req_type = REQ_QUERY;
    r.letter_0 = pick_amino();
    r.letter_1 = pick_amino();
    r.letter_2 = pick_amino();
    if (len > 3) r.letter_3 = pick_amino();
    if (len > 4) r.letter_4 = pick_amino();
    r.mutate_position = 3'($urandom_range(0, len - 1));
    return r;
  endfunction

  function automatic nwg_req_t broken_query();
    nwg_req_t r;
    logic [LetterW-1:0] junk;
    int len;
    len  = active_len();
    r    = good_query();
    junk = LetterW'($urandom_range(AlphabetSize, 31));
    if ($urandom_range(0, 1)) begin
      r.mutate_position = 3'($urandom_range(len, 7));
    end else begin
      case ($urandom_range(0, len - 1))
        0: r.letter_0 = junk;
        1: r.letter_1 = junk;
        2: r.letter_2 = junk;
        3: r.letter_3 = junk;
        default: r.letter_4 = junk;
      endcase
    end
    return r;
  endfunction

  // Rows of W and C are pinned to the score extremes so that the threshold
  // extremes can be hit exactly; the rest of the matrix is random.
  task automatic load_score_matrix();
    nwg_req_t r;
    int row;
    int col;
    for (row = 0; row < AlphabetSize; row++) begin
      for (col = 0; col < AlphabetSize; col++) begin
        r = entry_write();
        r.matrix_row = LetterW'(row);
        r.matrix_col = LetterW'(col);
        if (row == AMINO_W) r.entry_score = ScoreMax;
        else if (row == AMINO_C) r.entry_score = ScoreMin;
        send_item(r);
      end
    end
    repeat (4) send_item(stray_write());
  endtask

  task automatic test_reset_config_queries();
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), 5'd31, 5'd31, 0));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), 5'd27, 5'd20, 1));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd0, 2));
    send_item(make_query(pick_amino(), 5'd31, pick_amino(), pick_amino(), 5'd0, 0));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd0, 3));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd0, 7));
    // A write to the spare register index must leave every setting alone.
    wait_drain();
    cfg_write(CFG_UNUSED, CfgDataW'($urandom));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd0, 2));
  endtask

  task automatic test_threshold_extremes();
    set_config(5, 1'b1, MaxThreshold);
    send_item(make_query(AMINO_W, AMINO_W, AMINO_W, AMINO_W, AMINO_W, 0));
    send_item(make_query(AMINO_W, AMINO_W, AMINO_W, AMINO_W, AMINO_W, 4));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(),
                         pick_amino(), 2));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd20, 1));
    set_config(5, 1'b1, MinThreshold);
    send_item(make_query(AMINO_C, AMINO_C, AMINO_C, AMINO_C, AMINO_C, 3));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(),
                         pick_amino(), 0));
    set_config(5, 1'b1, MinThreshold + 1);
    send_item(make_query(AMINO_C, AMINO_C, AMINO_C, AMINO_C, AMINO_C, 1));
  endtask

  task automatic test_neighbor_disable();
    set_config(4, 1'b0, 11);
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd25, 0));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd25, 3));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(), 5'd25, 4));
  endtask

  task automatic test_seed_length_limits();
    set_config(7, 1'b1, 0);
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), pick_amino(),
                         pick_amino(), 4));
    set_config(1, 1'b1, 0);
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), 5'd31, 5'd31, 2));
    send_item(make_query(pick_amino(), pick_amino(), pick_amino(), 5'd31, 5'd31, 3));
  endtask

  // Mostly well-formed queries, with some matrix updates and some malformed beats.
  task automatic test_random_traffic();
    int phase;
    int n;
    int len;
    int thr;
    int pick;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 1, 2: len = MinSeedLen + phase;
        3:       len = 6 + $urandom_range(0, 1);
        4:       len = $urandom_range(0, 2);
        default: len = $urandom_range(MinSeedLen, MaxSeedLen);
      endcase
      case ($urandom_range(0, 3))
        0:       thr = MinThreshold;
        1:       thr = MaxThreshold;
        2:       thr = MinThreshold + int'($urandom_range(0, MaxThreshold - MinThreshold));
        default: thr = int'($urandom_range(0, 200)) - 100;
      endcase
      set_config(len, phase != 5, thr);
      no_gaps = (phase == 2);
      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      send_item(good_query());
        else if (pick < 85) send_item(entry_write());
        else if (pick < 93) send_item(broken_query());
        else                send_item(stray_write());
      end
      no_gaps = 1'b0;
    end
  endtask

  always @(posedge clk) begin : result_check
    nwg_res_t want;
    if (rst_ni && res_valid_o) begin
      results_checked++;
      if (res_o.found) words_found++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result key=%h word=%h found=%b last=%b",
                                  res_o.key_code, res_o.word_code, res_o.found, res_o.last));
      end else begin
        want = expected_words.pop_front();
        if (res_o.key_code !== want.key_code)
          report_mismatch($sformatf("key_code got %h want %h", res_o.key_code, want.key_code));
        if (res_o.word_code !== want.word_code)
          report_mismatch($sformatf("word_code got %h want %h (key %h)",
                                    res_o.word_code, want.word_code, want.key_code));
        if (res_o.found !== want.found)
          report_mismatch($sformatf("found got %b want %b (key %h)",
                                    res_o.found, want.found, want.key_code));
        if (res_o.last !== want.last)
          report_mismatch($sformatf("last got %b want %b (key %h word %h)",
                                    res_o.last, want.last, want.key_code, want.word_code));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Watchdog: no beat accepted for %0d cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    load_score_matrix();
    test_reset_config_queries();
    test_threshold_extremes();
    test_neighbor_disable();
    test_seed_length_limits();
    test_random_traffic();
    wait_drain();

    $display("Sent %0d matrix writes and %0d queries across %0d register writes.",
             writes_sent, queries_sent, cfg_writes);
    $display("Checked %0d result beats, %0d of them carrying a word.",
             results_checked, words_found);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
